[design/spq_pkg.sv]
// Sorted priority queue package: word types, command and status codes.
// Shared by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DataW = 16;
  localparam int PrioW = 8;
  localparam int OccW  = 5;

  // Command codes of an input word
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_REMOVED   = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic                     command;
    logic signed [DataW-1:0]  item_data;
    logic        [PrioW-1:0]  item_priority;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0]  out_data;
    status_e                  status;
    logic        [OccW-1:0]   occupancy;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_item;
    logic execute;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

`default_nettype wire

[design/sorted_priority_queue.sv]
// Sorted priority queue top level: controller plus datapath.
// A word waits in the item register until the result register can take its
// result. Throughput: one word per cycle, set by the single shift-chain
// update per word, unless a stalled receiver holds the result. Reset clears
// the entry count and handshake state; cells stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_word_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[design/spq_ctrl.sv]
// Sorted priority queue controller: tracks whether a word is pending
// and issues latch/execute commands. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_PEND = 1'b1;

  logic [0:0] state_q, state_d;
  logic       pend;

  assign pend = (state_q == S_PEND);

  // Pending word runs as soon as the result register can take its result
  assign cmd_o.execute    = pend && !status_i.out_blocked;
  assign in_stall_o       = pend && status_i.out_blocked;
  assign cmd_o.latch_item = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.latch_item) state_d = S_PEND;
      end
      S_PEND: begin
        if (cmd_o.latch_item) state_d = S_PEND;
        else if (cmd_o.execute) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/spq_datapath.sv]
// Sorted priority queue datapath: item register, sorted shift chain of
// cells, entry count and result register. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_word_t   in_word_i,
  input  wire ctrl_cmd_t  cmd_i,
  output dp_status_t      status_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_word_t       out_word_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  in_word_t                item_q;
  logic signed [DataW-1:0] data_q [DEPTH];
  logic signed [DataW-1:0] data_d [DEPTH];
  logic        [PrioW-1:0] prio_q [DEPTH];
  logic        [PrioW-1:0] prio_d [DEPTH];
  logic        [DEPTH-1:0] gt;
  logic        [CntW-1:0]  count_q, count_d;
  logic                    out_valid_q;
  out_word_t               out_q, out_d;
  logic                    full, empty, do_enq, do_deq;

  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_enq = cmd_i.execute && (item_q.command == CMD_ENQ) && !full;
  assign do_deq = cmd_i.execute && (item_q.command == CMD_DEQ) && !empty;

  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_word_o           = out_q;

  // Item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) item_q <= in_word_i;
  end

  // Each cell flags whether it holds a larger priority or is empty
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      gt[k] = (CntW'(k) >= count_q) || (prio_q[k] > item_q.item_priority);
    end
  end

  // Shift chain: insert at the first larger cell, or shift toward front
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      data_d[k] = data_q[k];
      prio_d[k] = prio_q[k];
      if (do_enq) begin
        if (k > 0 && gt[k-1]) begin
          data_d[k] = data_q[k-1];
          prio_d[k] = prio_q[k-1];
        end else if (gt[k]) begin
          data_d[k] = item_q.item_data;
          prio_d[k] = item_q.item_priority;
        end
      end else if (do_deq && k < DEPTH - 1) begin
        data_d[k] = data_q[k+1];
        prio_d[k] = prio_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DEPTH; k++) begin
      data_q[k] <= data_d[k];
      prio_q[k] <= prio_d[k];
    end
  end

  // Entry count and result word
  always_comb begin
    count_d           = count_q;
    out_d.out_data    = '0;
    out_d.status      = STAT_INSERTED;
    if (item_q.command == CMD_ENQ) begin
      if (full) begin
        out_d.status = STAT_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        out_d.status = STAT_UNDERFLOW;
      end else begin
        out_d.status   = STAT_REMOVED;
        out_d.out_data = data_q[0];
        count_d        = count_q - CntW'(1);
      end
    end
    out_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) out_q <= out_d;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |=> out_valid_q)
    else $error("executed word left no result");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(count_q))
    else $error("count moved without a word");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_enq |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow count");

  a_exec_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

endmodule

`default_nettype wire

[bench/tb_sorted_priority_queue.sv]
// Self-checking bench for sorted_priority_queue: a directed table, then biased random traffic.
// A shadow sorted queue predicts each result word that the table does not give. Depends on spq_pkg and the design.
`timescale 1ns / 1ps

module tb_sorted_priority_queue
  import spq_pkg::*;
();

  localparam int QueueDepth = 16;

  typedef struct packed {
    in_word_t  word;
    logic      known;
    out_word_t result;
  } vector_t;

  logic      clk;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // Shadow copy of the queue contents, front at slot 0
  logic signed [DataW-1:0] shadow_data [QueueDepth];
  logic        [PrioW-1:0] shadow_prio [QueueDepth];
  int                      shadow_count;

  out_word_t awaited_replies [$];
  vector_t   directed_vectors [$];

  // Tag of the word on the input bus: a typed-in reply, if any
  logic      word_known;
  out_word_t word_reply;

  int errors;
  int idle_pct;
  int stall_pct;
  bit hold_off_req;

  sorted_priority_queue #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one word to the shadow queue and return the reply it should give
  function automatic out_word_t apply_to_shadow_queue(in_word_t w);
    out_word_t r;
    int pos;
    int k;
    r.out_data = '0;
    if (w.command == CMD_ENQ) begin
      if (shadow_count >= QueueDepth) begin
        r.status = STAT_FULL;
      end else begin
        // equal priorities stay in arrival order
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= w.item_priority) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_data[k] = shadow_data[k-1];
          shadow_prio[k] = shadow_prio[k-1];
        end
        shadow_data[pos] = w.item_data;
        shadow_prio[pos] = w.item_priority;
        shadow_count++;
        r.status = STAT_INSERTED;
      end
    end else if (shadow_count == 0) begin
      r.status = STAT_UNDERFLOW;
    end else begin
      r.out_data = shadow_data[0];
      for (k = 1; k < shadow_count; k++) begin
        shadow_data[k-1] = shadow_data[k];
        shadow_prio[k-1] = shadow_prio[k];
      end
      shadow_count--;
      r.status = STAT_REMOVED;
    end
    r.occupancy = OccW'(shadow_count);
    return r;
  endfunction

  // Check accepted replies, then record accepted words
  always @(posedge clk) begin : reply_check
    out_word_t want;
    out_word_t pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected reply data=%0d status=%s occ=%0d", $realtime,
                   out_word_o.out_data, out_word_o.status.name(), out_word_o.occupancy);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_word_o.out_data !== want.out_data || out_word_o.status !== want.status ||
              out_word_o.occupancy !== want.occupancy) begin
            $display("%0t: expected %0d/%s/%0d, actual %0d/%s/%0d (data/status/occ)",
                     $realtime, want.out_data, want.status.name(), want.occupancy,
                     out_word_o.out_data, out_word_o.status.name(), out_word_o.occupancy);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pred = apply_to_shadow_queue(in_word_i);
        awaited_replies.push_back(word_known ? word_reply : pred);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (59) @(negedge clk);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one word, called and returning at a falling edge
  task automatic send_word(input in_word_t w, input logic known, input out_word_t reply);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      in_word_i  <= in_word_t'($urandom);
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    word_known <= known;
    word_reply <= reply;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  task automatic add_vector(input logic cmd, input int data, input int prio, input logic known,
                            input int rdata, input status_e st, input int occ);
    vector_t v;
    v.word.command       = cmd;
    v.word.item_data     = DataW'(data);
    v.word.item_priority = PrioW'(prio);
    v.known              = known;
    v.result.out_data    = DataW'(rdata);
    v.result.status      = st;
    v.result.occupancy   = OccW'(occ);
    directed_vectors.push_back(v);
  endtask

  // Stimulus
  initial begin : stimulus
    int fill_prio [16];
    in_word_t w;
    int enq_pct;
    int prio_max;
    int drain_cycles;
    fill_prio = '{9, 3, 255, 3, 0, 128, 9, 200, 1, 3, 0, 77, 255, 4, 9, 5};
    errors       = 0;
    shadow_count = 0;
    idle_pct     = 21;
    stall_pct    = 21;
    hold_off_req = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    word_known   = 1'b0;
    word_reply   = '0;
    rst_ni       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Directed table: empty, extremes, equal-priority order, fill, full
    add_vector(CMD_DEQ, 0, 0, 1, 0, STAT_UNDERFLOW, 0);
    add_vector(CMD_ENQ, 32767, 255, 1, 0, STAT_INSERTED, 1);
    add_vector(CMD_ENQ, -32768, 0, 1, 0, STAT_INSERTED, 2);
    add_vector(CMD_ENQ, 16'h1234, 0, 1, 0, STAT_INSERTED, 3);
    add_vector(CMD_DEQ, 32767, 255, 1, -32768, STAT_REMOVED, 2);
    add_vector(CMD_DEQ, -1, 0, 1, 16'h1234, STAT_REMOVED, 1);
    add_vector(CMD_DEQ, 0, 0, 1, 32767, STAT_REMOVED, 0);
    add_vector(CMD_DEQ, -32768, 255, 1, 0, STAT_UNDERFLOW, 0);
    foreach (fill_prio[i]) add_vector(CMD_ENQ, 1000 * i - 7000, fill_prio[i], 0, 0,
                                      STAT_INSERTED, 0);
    add_vector(CMD_ENQ, 16'h5555, 2, 1, 0, STAT_FULL, 16);
    @(negedge clk);
    foreach (directed_vectors[i])
      send_word(directed_vectors[i].word, directed_vectors[i].known,
                directed_vectors[i].result);

    // Random phases: fill-heavy, balanced, drain-heavy; mostly narrow priorities for ties
    for (int chunk = 0; chunk < 16; chunk++) begin
      case (chunk % 4)
        0:       enq_pct = 80;
        2:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      prio_max = (chunk % 3 == 0) ? 255 : 7;
      if (chunk == 4) hold_off_req = 1'b1;
      // one quiet stretch with no idling on either side
      idle_pct  = (chunk == 6) ? 0 : 21;
      stall_pct = (chunk == 6) ? 0 : 21;
      repeat (95) begin
        w.command       = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        w.item_data     = DataW'($urandom);
        w.item_priority = PrioW'($urandom_range(0, prio_max));
        send_word(w, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // Drain
    drain_cycles = 0;
    while (awaited_replies.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (awaited_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $realtime, awaited_replies.size());
      errors++;
    end
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
